[sv/mmio_trap_access_decoder_unit_macros.svh]
// assertion helpers used by mmio_trap_access_decoder_unit.sv
`ifndef MMIO_TRAP_ACCESS_DECODER_UNIT_MACROS_SVH
`define MMIO_TRAP_ACCESS_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define MTAD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mtad assertion failed");
`define MTAD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mtad assertion failed");
`else
`define MTAD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MTAD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/mtad_pkg.sv]
package mtad_pkg;

	localparam int XLEN = 64;
	localparam logic [4:0] COMPRESSED_REG_BASE = 5'd8;
	localparam logic [63:0] XLEN_MASK = {64{1'b1}} >> (64 - XLEN);

	localparam logic CMD_DECODE   = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	localparam logic [2:0] ST_OK              = 3'd0;
	localparam logic [2:0] ST_NO_HTVAL        = 3'd1;
	localparam logic [2:0] ST_ODD_PC          = 3'd2;
	localparam logic [2:0] ST_UNSUPPORTED     = 3'd3;
	localparam logic [2:0] ST_NOT_HANDLED     = 3'd4;
	localparam logic [2:0] ST_NOTHING_PENDING = 3'd5;

	localparam logic [1:0] QUAD_C0   = 2'b00;
	localparam logic [1:0] QUAD_FULL = 2'b11;
	localparam logic [2:0] C_F3_LW   = 3'd2;
	localparam logic [2:0] C_F3_SW   = 3'd6;
	localparam logic [4:0] OPC_LOAD  = 5'h00;
	localparam logic [4:0] OPC_STORE = 5'h08;
	localparam logic [2:0] WID_WORD  = 3'd2;

	localparam logic [2:0] BYTES_1 = 3'd1;
	localparam logic [2:0] BYTES_2 = 3'd2;
	localparam logic [2:0] BYTES_4 = 3'd4;

	typedef struct packed {
		logic        command;
		logic        write_fault;
		logic [61:0] fault_gpa_shifted;
		logic [1:0]  fault_low_bits;
		logic [63:0] guest_pc;
		logic [15:0] inst_first_half;
		logic [15:0] inst_second_half;
		logic        access_done;
		logic [63:0] read_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] access_address;
		logic [2:0]  access_bytes;
		logic        access_is_store;
		logic [4:0]  reg_index;
		logic        short_form;
		logic        writeback_enable;
		logic [63:0] writeback_value;
		logic [63:0] next_pc;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic        store;
		logic [2:0]  bytes;
		logic [4:0]  reg_index;
		logic        short_form;
		logic [63:0] pc;
	} pend_t;

endpackage

[sv/mmio_trap_access_decoder_unit.sv]
// channel  | direction | handshake            | payload
// request  | in        | req_valid/req_ready  | req (fault decode or completion)
// response | out       | rsp_valid/rsp_ready  | rsp (status and access fields)
//
// one request per cycle unless req_ready drops; a response passes the request and response registers
// the request register feeds decode/complete logic straight into the response register
// pending access state updates as a request moves into the response register
// a stalled response holds the request register; req_ready drops only with both full
// arst_n clears valids and the pending access
`include "mmio_trap_access_decoder_unit_macros.svh"

module mmio_trap_access_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mtad_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mtad_pkg::rsp_t rsp
);
	import mtad_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	logic  valid_s2;
	rsp_t  rsp_s2;
	pend_t pend_q;
	logic  adv;
	logic  dec_ok;
	rsp_t  dec_rsp;
	rsp_t  cmp_rsp;
	rsp_t  rsp_next;

	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	mtad_decode u_decode (
		.req (req_s1),
		.ok  (dec_ok),
		.rsp (dec_rsp)
	);

	mtad_complete u_complete (
		.pend        (pend_q),
		.access_done (req_s1.access_done),
		.read_data   (req_s1.read_data),
		.rsp         (cmp_rsp)
	);

	assign rsp_next = (req_s1.command == CMD_COMPLETE) ? cmp_rsp : dec_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= rsp_next;
		end
	end

	// pending access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (adv) begin
			if (req_s1.command == CMD_COMPLETE) begin
				pend_q.valid <= 1'b0;
			end else begin
				pend_q.valid <= dec_ok;
				if (dec_ok) begin
					pend_q.store      <= dec_rsp.access_is_store;
					pend_q.bytes      <= dec_rsp.access_bytes;
					pend_q.reg_index  <= dec_rsp.reg_index;
					pend_q.short_form <= dec_rsp.short_form;
					pend_q.pc         <= req_s1.guest_pc;
				end
			end
		end
	end

	`MTAD_ASSERT_NXT(a_complete_drops, clk, arst_n, adv && req_s1.command == CMD_COMPLETE, !pend_q.valid)
	`MTAD_ASSERT_NXT(a_fail_drops, clk, arst_n, adv && req_s1.command == CMD_DECODE && !dec_ok, !pend_q.valid)
	`MTAD_ASSERT_IMP(a_wb_only_ok, clk, arst_n, valid_s2 && rsp_s2.writeback_enable, rsp_s2.status == ST_OK && !rsp_s2.access_is_store)
	`MTAD_ASSERT_IMP(a_pend_width, clk, arst_n, pend_q.valid, pend_q.bytes == BYTES_1 || pend_q.bytes == BYTES_2 || pend_q.bytes == BYTES_4)
	`MTAD_ASSERT_IMP(a_stall_full, clk, arst_n, !req_ready, valid_s1 && valid_s2 && !rsp_ready)

endmodule

[sv/mtad_decode.sv]
module mtad_decode (
	input  mtad_pkg::req_t req,
	output logic           ok,
	output mtad_pkg::rsp_t rsp
);
	import mtad_pkg::*;

	logic [31:0] word;
	logic [4:0]  opc;
	logic [2:0]  wid;
	logic [2:0]  cf3;
	logic        inst_ok;
	logic        is_short;
	logic [2:0]  bytes;
	logic [4:0]  rd_rs;

	assign word = {req.inst_second_half, req.inst_first_half};
	assign opc  = word[6:2];
	assign wid  = word[14:12];
	assign cf3  = req.inst_first_half[15:13];

	always_comb begin
		inst_ok  = 1'b0;
		is_short = 1'b0;
		bytes    = BYTES_4;
		rd_rs    = '0;
		if (req.inst_first_half[1:0] != QUAD_FULL) begin
			is_short = 1'b1;
			rd_rs    = {2'b00, req.inst_first_half[4:2]} + COMPRESSED_REG_BASE;
			inst_ok  = (req.inst_first_half[1:0] == QUAD_C0) &&
				((cf3 == C_F3_LW) || (cf3 == C_F3_SW));
		end else begin
			bytes = 3'(3'd1 << wid[1:0]);
			if (wid <= WID_WORD) begin
				if (opc == OPC_LOAD) begin
					inst_ok = 1'b1;
					rd_rs   = word[11:7];
				end else if (opc == OPC_STORE) begin
					inst_ok = 1'b1;
					rd_rs   = word[24:20];
				end
			end
		end
	end

	always_comb begin
		rsp = '0;
		ok  = 1'b0;
		if (req.fault_gpa_shifted == '0) begin
			rsp.status = ST_NO_HTVAL;
		end else if (req.guest_pc[0]) begin
			rsp.status = ST_ODD_PC;
		end else if (!inst_ok) begin
			rsp.status = ST_UNSUPPORTED;
		end else begin
			ok                  = 1'b1;
			rsp.status          = ST_OK;
			rsp.access_address  = {req.fault_gpa_shifted, req.fault_low_bits};
			rsp.access_bytes    = bytes;
			rsp.access_is_store = req.write_fault;
			rsp.reg_index       = rd_rs;
			rsp.short_form      = is_short;
		end
	end

endmodule

[sv/mtad_complete.sv]
module mtad_complete (
	input  mtad_pkg::pend_t pend,
	input  logic            access_done,
	input  logic [63:0]     read_data,
	output mtad_pkg::rsp_t  rsp
);
	import mtad_pkg::*;

	logic [63:0] ext;
	logic [63:0] pc_inc;

	always_comb begin
		case (pend.bytes)
			BYTES_1: ext = {{56{read_data[7]}}, read_data[7:0]};
			BYTES_2: ext = {{48{read_data[15]}}, read_data[15:0]};
			BYTES_4: ext = {{32{read_data[31]}}, read_data[31:0]};
			default: ext = read_data;
		endcase
	end

	assign pc_inc = pend.pc + (pend.short_form ? 64'd2 : 64'd4);

	always_comb begin
		rsp = '0;
		if (!pend.valid) begin
			rsp.status = ST_NOTHING_PENDING;
		end else begin
			rsp.access_bytes    = pend.bytes;
			rsp.access_is_store = pend.store;
			rsp.reg_index       = pend.reg_index;
			rsp.short_form      = pend.short_form;
			if (!access_done) begin
				rsp.status = ST_NOT_HANDLED;
			end else begin
				rsp.status  = ST_OK;
				rsp.next_pc = pc_inc & XLEN_MASK;
				if (!pend.store) begin
					rsp.writeback_enable = 1'b1;
					rsp.writeback_value  = ext & XLEN_MASK;
				end
			end
		end
	end

endmodule

[test/mmio_trap_access_decoder_unit_test.sv]
module mmio_trap_access_decoder_unit_test;
	import mtad_pkg::*;

	localparam logic [4:0] OPC_OP_IMM    = 5'h04;
	localparam logic [2:0] WID_BYTE      = 3'd0;
	localparam logic [2:0] WID_HALF      = 3'd1;
	localparam logic [2:0] WID_DOUBLE    = 3'd3;
	localparam logic [2:0] WID_BAD       = 3'd7;
	localparam logic [1:0] QUAD_C1       = 2'b01;
	localparam logic [2:0] C_F3_ADDI4SPN = 3'd0;
	localparam int         RANDOM_ITEMS  = 1450;

	typedef struct {
		logic hold_for_drain;
		req_t item;
	} queued_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	queued_t request_q[$];
	rsp_t    result_q[$];
	pend_t   pending_access;

	logic req_fire;
	int   errors;
	int   n_rsp;
	int   n_decode;
	int   n_complete;
	int   n_pauses;
	int   status_seen[0:7];
	int   gap_left;
	int   burst_left;
	int   hold_left;
	int   holds_done;
	int   rx_cycle;

	mmio_trap_access_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [61:0] rand_gpa();
		logic [61:0] g;
		g = 62'(rand64());
		if (g == '0) begin
			g = 62'd1;
		end
		return g;
	endfunction

	function automatic logic [31:0] full_inst(logic [4:0] opc, logic [2:0] wid, logic [4:0] rg);
		logic [31:0] w;
		w = $urandom;
		w[1:0] = QUAD_FULL;
		w[6:2] = opc;
		w[14:12] = wid;
		if (opc == OPC_STORE) begin
			w[24:20] = rg;
		end else begin
			w[11:7] = rg;
		end
		return w;
	endfunction

	function automatic logic [31:0] short_inst(logic [1:0] quad, logic [2:0] f3, logic [2:0] rg);
		logic [31:0] w;
		w = $urandom;
		w[1:0] = quad;
		w[15:13] = f3;
		w[4:2] = rg;
		return w;
	endfunction

	function automatic req_t mk_decode(logic wr, logic [61:0] gpa, logic [1:0] lo,
			logic [63:0] pc, logic [31:0] inst);
		req_t r;
		r.command = CMD_DECODE;
		r.write_fault = wr;
		r.fault_gpa_shifted = gpa;
		r.fault_low_bits = lo;
		r.guest_pc = pc;
		r.inst_first_half = inst[15:0];
		r.inst_second_half = inst[31:16];
		r.access_done = 1'($urandom_range(0, 1));
		r.read_data = rand64();
		return r;
	endfunction

	function automatic req_t mk_complete(logic done, logic [63:0] data);
		req_t r;
		r = mk_decode(1'($urandom_range(0, 1)), 62'(rand64()), 2'($urandom_range(0, 3)),
			rand64(), $urandom);
		r.command = CMD_COMPLETE;
		r.access_done = done;
		r.read_data = data;
		return r;
	endfunction

	// random supported load or store, direction usually matching the fault
	function automatic req_t mk_good_decode();
		int          kind;
		logic        wr;
		logic [31:0] inst;
		kind = $urandom_range(0, 7);
		case (kind)
			0, 1, 2: inst = full_inst(OPC_LOAD, 3'(kind), 5'($urandom));
			3, 4, 5: inst = full_inst(OPC_STORE, 3'(kind - 3), 5'($urandom));
			6:       inst = short_inst(QUAD_C0, C_F3_LW, 3'($urandom));
			default: inst = short_inst(QUAD_C0, C_F3_SW, 3'($urandom));
		endcase
		wr = (kind >= 3 && kind != 6);
		if ($urandom_range(0, 9) == 0) begin
			wr = !wr;
		end
		return mk_decode(wr, rand_gpa(), 2'($urandom_range(0, 3)), rand64() & ~64'd1, inst);
	endfunction

	function automatic req_t mk_noise();
		req_t r;
		r = mk_decode(1'($urandom_range(0, 1)), 62'(rand64()), 2'($urandom_range(0, 3)),
			rand64(), $urandom);
		r.command = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) begin
			r.fault_gpa_shifted = '0;
		end
		return r;
	endfunction

	task automatic add(req_t r, logic drain = 1'b0);
		queued_t q;
		q.hold_for_drain = drain;
		q.item = r;
		request_q.push_back(q);
	endtask

	function automatic rsp_t emulate_trap(req_t r);
		rsp_t        o;
		logic [31:0] w;
		logic [2:0]  f3;
		logic [2:0]  wid;
		logic [4:0]  opc;
		logic        ok;
		logic        sh;
		logic [2:0]  nb;
		logic [4:0]  rg;
		int          bits;
		logic [63:0] v;
		logic [63:0] sgn;
		o = '0;
		if (r.command == CMD_DECODE) begin
			pending_access.valid = 1'b0;
			if (r.fault_gpa_shifted == '0) begin
				o.status = ST_NO_HTVAL;
			end else if (r.guest_pc[0]) begin
				o.status = ST_ODD_PC;
			end else begin
				w = {r.inst_second_half, r.inst_first_half};
				ok = 1'b0;
				nb = '0;
				rg = '0;
				if (w[1:0] != QUAD_FULL) begin
					sh = 1'b1;
					f3 = w[15:13];
					if (w[1:0] == QUAD_C0 && (f3 == C_F3_LW || f3 == C_F3_SW)) begin
						ok = 1'b1;
						nb = BYTES_4;
						rg = {2'b00, w[4:2]} + COMPRESSED_REG_BASE;
					end
				end else begin
					sh = 1'b0;
					opc = w[6:2];
					wid = w[14:12];
					if (wid <= WID_WORD && (opc == OPC_LOAD || opc == OPC_STORE)) begin
						ok = 1'b1;
						nb = 3'd1 << wid;
						rg = (opc == OPC_LOAD) ? w[11:7] : w[24:20];
					end
				end
				if (!ok) begin
					o.status = ST_UNSUPPORTED;
				end else begin
					pending_access.valid = 1'b1;
					pending_access.store = r.write_fault;
					pending_access.bytes = nb;
					pending_access.reg_index = rg;
					pending_access.short_form = sh;
					pending_access.pc = r.guest_pc;
					o.status = ST_OK;
					o.access_address = {r.fault_gpa_shifted, r.fault_low_bits};
					o.access_bytes = nb;
					o.access_is_store = r.write_fault;
					o.reg_index = rg;
					o.short_form = sh;
				end
			end
		end else if (!pending_access.valid) begin
			o.status = ST_NOTHING_PENDING;
		end else begin
			o.access_bytes = pending_access.bytes;
			o.access_is_store = pending_access.store;
			o.reg_index = pending_access.reg_index;
			o.short_form = pending_access.short_form;
			pending_access.valid = 1'b0;
			if (!r.access_done) begin
				o.status = ST_NOT_HANDLED;
			end else begin
				o.status = ST_OK;
				if (!pending_access.store) begin
					bits = int'(pending_access.bytes) * 8;
					v = r.read_data;
					if (bits >= 1 && bits < 64) begin
						sgn = 64'd1 << (bits - 1);
						v = ((v & ((64'd1 << bits) - 64'd1)) ^ sgn) - sgn;
					end
					o.writeback_enable = 1'b1;
					o.writeback_value = v & XLEN_MASK;
				end
				o.next_pc = (pending_access.pc + (pending_access.short_form ? 64'd2 : 64'd4))
					& XLEN_MASK;
			end
		end
		return o;
	endfunction

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 40) begin
				$display("%0t: %s expected %h got %h", $time, what, want, got);
			end
		end
	endtask

	// requests and responses are both taken at the rising edge
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: response with nothing expected, expected none got status %0d",
						$time, rsp.status);
				end else begin
					want = result_q.pop_front();
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("access_address", want.access_address, rsp.access_address);
					check_field("access_bytes", 64'(want.access_bytes), 64'(rsp.access_bytes));
					check_field("access_is_store", 64'(want.access_is_store),
						64'(rsp.access_is_store));
					check_field("reg_index", 64'(want.reg_index), 64'(rsp.reg_index));
					check_field("short_form", 64'(want.short_form), 64'(rsp.short_form));
					check_field("writeback_enable", 64'(want.writeback_enable),
						64'(rsp.writeback_enable));
					check_field("writeback_value", want.writeback_value, rsp.writeback_value);
					check_field("next_pc", want.next_pc, rsp.next_pc);
				end
			end
			if (req_valid && req_ready) begin
				want = emulate_trap(req);
				result_q.push_back(want);
				status_seen[want.status]++;
				if (req.command == CMD_DECODE) begin
					n_decode++;
				end else begin
					n_complete++;
				end
				req_fire = 1'b1;
			end
		end
	end

	// sender: bursts and gaps, an optional pause until all responses are in
	always @(negedge clk) begin : drive
		logic keep;
		keep = req_valid && !req_fire;
		req_fire = 1'b0;
		if (!arst_n || keep) begin
		end else if (gap_left > 0) begin
			gap_left--;
			req_valid <= 1'b0;
		end else if (request_q.size() == 0) begin
			req_valid <= 1'b0;
		end else if (request_q[0].hold_for_drain && result_q.size() != 0) begin
			req_valid <= 1'b0;
		end else begin
			if (request_q[0].hold_for_drain) begin
				n_pauses++;
			end
			req <= request_q[0].item;
			req_valid <= 1'b1;
			void'(request_q.pop_front());
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
				case ($urandom_range(0, 5))
					0, 1:    gap_left = 0;
					5:       gap_left = $urandom_range(8, 20);
					default: gap_left = $urandom_range(1, 4);
				endcase
			end
		end
	end

	// receiver: rotating stall patterns plus two long hold-offs
	always @(negedge clk) begin : sink
		if (arst_n) begin
			rx_cycle++;
			if (hold_left == 0 && holds_done < 2 && n_rsp >= 400 + 500 * holds_done) begin
				hold_left = 300;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 300) % 4)
					0:       rsp_ready <= 1'b1;
					1:       rsp_ready <= ($urandom_range(0, 1) == 1);
					2:       rsp_ready <= (rx_cycle % 4 != 3);
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int pick;
		int next_drain;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_ready = 1'b0;
		req = '0;
		req_fire = 1'b0;
		pending_access = '0;
		errors = 0;
		n_rsp = 0;
		n_decode = 0;
		n_complete = 0;
		n_pauses = 0;
		status_seen = '{default: 0};
		gap_left = 0;
		burst_left = 0;
		hold_left = 0;
		holds_done = 0;
		rx_cycle = 0;

		// directed: completion with nothing pending, then every load/store form
		add(mk_complete(1'b1, rand64()));
		add(mk_decode(1'b0, '1, 2'd3, 64'd0, full_inst(OPC_LOAD, WID_BYTE, 5'd0)));
		add(mk_complete(1'b1, 64'h0000_0000_0000_0080));
		add(mk_decode(1'b0, 62'd1, 2'd0, rand64() & ~64'd1, full_inst(OPC_LOAD, WID_HALF, 5'd31)));
		add(mk_complete(1'b1, 64'hFFFF_FFFF_FFFF_8000));
		add(mk_decode(1'b0, rand_gpa(), 2'd1, 64'hFFFF_FFFF_FFFF_FFFC,
			full_inst(OPC_LOAD, WID_WORD, 5'd5)));
		add(mk_complete(1'b1, 64'h1234_5678_8000_0000));
		add(mk_decode(1'b1, rand_gpa(), 2'd2, rand64() & ~64'd1, full_inst(OPC_STORE, WID_BYTE, 5'd17)));
		add(mk_complete(1'b1, rand64()));
		add(mk_decode(1'b1, rand_gpa(), 2'd0, rand64() & ~64'd1, full_inst(OPC_STORE, WID_HALF, 5'd0)));
		add(mk_complete(1'b0, rand64()));
		add(mk_complete(1'b1, rand64()));
		// decode while pending replaces the request
		add(mk_decode(1'b1, rand_gpa(), 2'd3, rand64() & ~64'd1, full_inst(OPC_STORE, WID_WORD, 5'd9)));
		add(mk_decode(1'b0, rand_gpa(), 2'd1, rand64() & ~64'd1, short_inst(QUAD_C0, C_F3_LW, 3'd7)));
		add(mk_complete(1'b1, 64'h0000_0000_FFFF_FFFF));
		add(mk_decode(1'b1, rand_gpa(), 2'd0, 64'hFFFF_FFFF_FFFF_FFFE,
			short_inst(QUAD_C0, C_F3_SW, 3'd0)));
		add(mk_complete(1'b1, rand64()));
		// store fault on a load encoding
		add(mk_decode(1'b1, rand_gpa(), 2'd2, rand64() & ~64'd1, full_inst(OPC_LOAD, WID_WORD, 5'd3)));
		add(mk_complete(1'b1, rand64()));
		// rejected decodes, the first one dropping a pending request
		add(mk_decode(1'b0, rand_gpa(), 2'd0, rand64() & ~64'd1, full_inst(OPC_LOAD, WID_WORD, 5'd1)));
		add(mk_decode(1'b0, '0, 2'd1, rand64() & ~64'd1, full_inst(OPC_LOAD, WID_WORD, 5'd1)));
		add(mk_complete(1'b1, rand64()));
		add(mk_decode(1'b0, rand_gpa(), 2'd0, '1, full_inst(OPC_LOAD, WID_BYTE, 5'd2)));
		add(mk_decode(1'b0, rand_gpa(), 2'd0, 64'd2, full_inst(OPC_OP_IMM, WID_WORD, 5'd2)));
		add(mk_decode(1'b1, rand_gpa(), 2'd0, 64'd4, full_inst(OPC_STORE, WID_DOUBLE, 5'd2)));
		add(mk_decode(1'b0, rand_gpa(), 2'd0, 64'd8, full_inst(OPC_LOAD, WID_BAD, 5'd2)));
		add(mk_decode(1'b0, rand_gpa(), 2'd0, 64'd6, short_inst(QUAD_C1, C_F3_LW, 3'd2)));
		add(mk_decode(1'b0, rand_gpa(), 2'd0, 64'd10, short_inst(QUAD_C0, C_F3_ADDI4SPN, 3'd2)));

		// random: mostly decode/complete pairs, some replacements and noise
		next_drain = request_q.size();
		while (request_q.size() < RANDOM_ITEMS) begin
			logic drain;
			drain = 1'b0;
			if (request_q.size() >= next_drain) begin
				drain = 1'b1;
				next_drain += $urandom_range(150, 250);
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				add(mk_good_decode(), drain);
				add(mk_complete($urandom_range(0, 9) != 0, rand64()));
			end else if (pick < 75) begin
				add(mk_good_decode(), drain);
				add(mk_good_decode());
				add(mk_complete($urandom_range(0, 9) != 0, rand64()));
			end else begin
				add(mk_noise(), drain);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || req_valid || result_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("covered %0d requests (%0d decodes, %0d completions), %0d sender pauses, %0d long stalls",
			n_decode + n_complete, n_decode, n_complete, n_pauses, holds_done);
		$display("outcomes: ok %0d, no htval %0d, odd pc %0d, unsupported %0d, not handled %0d, idle %0d",
			status_seen[ST_OK], status_seen[ST_NO_HTVAL], status_seen[ST_ODD_PC],
			status_seen[ST_UNSUPPORTED], status_seen[ST_NOT_HANDLED], status_seen[ST_NOTHING_PENDING]);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
